[hdl/tls_rx_pkg.sv]
// Shared types, codes and limits for the TLS 1.2 record receive checker.
// No dependencies; compile first.
`default_nettype none

package tls_rx_pkg;

    // Record limits and AEAD framing
    localparam int MAX_PLAINTEXT  = 16384;
    localparam int MAX_CIPHERTEXT = 18432;
    localparam int TAG_BYTES      = 16;
    localparam logic [3:0] GCM_EXPLICIT_BYTES = 4'd8;

    // TLS alert descriptions
    localparam logic [7:0] ALERT_NONE         = 8'd0;
    localparam logic [7:0] ALERT_UNEXPECTED   = 8'd10;
    localparam logic [7:0] ALERT_BAD_MAC      = 8'd20;
    localparam logic [7:0] ALERT_REC_OVERFLOW = 8'd22;
    localparam logic [7:0] ALERT_DECODE       = 8'd50;
    localparam logic [7:0] ALERT_BAD_VERSION  = 8'd70;

    // Record content types
    localparam logic [7:0] CT_CCS       = 8'd20;
    localparam logic [7:0] CT_ALERT     = 8'd21;
    localparam logic [7:0] CT_HANDSHAKE = 8'd22;
    localparam logic [7:0] CT_APPDATA   = 8'd23;

    // Record version bytes
    localparam logic [7:0] VER_MAJOR_TLS  = 8'd3;
    localparam logic [7:0] VER_MINOR_TLS12 = 8'd3;
    localparam logic [7:0] VER_MINOR_TLS10 = 8'd1;

    // ChangeCipherSpec body
    localparam logic [15:0] CCS_LEN  = 16'd1;
    localparam logic [7:0]  CCS_BODY = 8'd1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_READ_ACTIVE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AEAD_CHACHA = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IV_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEQ_LIMIT   = 3'd4;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [2:0] {
        ST_DELIVER   = 3'd0,
        ST_DROPPED   = 3'd1,
        ST_OPEN      = 3'd2,
        ST_PROTO_ERR = 3'd3,
        ST_MAC_ERR   = 3'd4
    } status_t;

    typedef struct packed {
        logic        read_active;
        logic        aead_chacha;
        logic [31:0] iv_high;
        logic [63:0] iv_low;
        logic [63:0] seq_limit;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  content_type;
        logic [7:0]  version_major;
        logic [7:0]  version_minor;
        logic [15:0] record_len;
        logic [7:0]  first_body_byte;
        logic [63:0] explicit_nonce;
        logic        tag_ok;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  alert_code;
        logic [14:0] plain_len;
        logic [3:0]  body_offset;
        logic [63:0] seq_used;
        logic [31:0] nonce_high;
        logic [63:0] nonce_low;
    } result_t;

    typedef struct packed {
        logic        first_record;
        logic [63:0] read_seq;
        logic        open_pending;
        logic [7:0]  pending_type;
        logic [14:0] pending_len;
    } state_t;

endpackage

`default_nettype wire

[hdl/tls_rx_if.sv]
// Valid/ready channel interfaces: record items in, check results out.
// Standalone; no package dependency.
`default_nettype none

interface tls_rx_rec_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  content_type;
    logic [7:0]  version_major;
    logic [7:0]  version_minor;
    logic [15:0] record_len;
    logic [7:0]  first_body_byte;
    logic [63:0] explicit_nonce;
    logic        tag_ok;

    modport source (
        output valid, kind, content_type, version_major, version_minor,
               record_len, first_body_byte, explicit_nonce, tag_ok,
        input  ready
    );
    modport sink (
        input  valid, kind, content_type, version_major, version_minor,
               record_len, first_body_byte, explicit_nonce, tag_ok,
        output ready
    );
endinterface

interface tls_rx_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  alert_code;
    logic [14:0] plain_len;
    logic [3:0]  body_offset;
    logic [63:0] seq_used;
    logic [31:0] nonce_high;
    logic [63:0] nonce_low;

    modport source (
        output valid, status, alert_code, plain_len, body_offset, seq_used,
               nonce_high, nonce_low,
        input  ready
    );
    modport sink (
        input  valid, status, alert_code, plain_len, body_offset, seq_used,
               nonce_high, nonce_low,
        output ready
    );
endinterface

`default_nettype wire

[hdl/tls12_record_receive_checker.sv]
// TLS 1.2 record receive checker, top level.
// The input register takes a transaction and the result register takes its verdict
//   once the result register is free or being drained, so a busy sink can stall it.
// Throughput one item per cycle, limited only by the sink. Reset (rst_n, asynchronous,
//   active low) empties both stages, restores register defaults and sets first_record.
// Depends on tls_rx_pkg, tls_rx_if, tls_rx_cfg and tls_rx_eval.
`default_nettype none

module tls12_record_receive_checker #(
    parameter int MAX_PLAINTEXT  = tls_rx_pkg::MAX_PLAINTEXT,
    parameter int MAX_CIPHERTEXT = tls_rx_pkg::MAX_CIPHERTEXT,
    parameter int TAG_BYTES      = tls_rx_pkg::TAG_BYTES
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    tls_rx_rec_if.sink                             rec_in,
    tls_rx_res_if.source                           res_out,
    input  wire logic                              cfg_we,
    input  wire logic [tls_rx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tls_rx_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tls_rx_pkg::*;

    cfg_t    cfg;
    logic    seq_clear;

    // Input stage
    logic    s1_valid_reg;
    item_t   s1_item_reg;
    item_t   in_item;

    // Result stage
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t eval_res;

    // Record state carried between transactions
    state_t  st_reg;
    state_t  st_eval;

    logic    advance;
    logic    in_take;

    tls_rx_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .seq_clear (seq_clear)
    );

    // Gather the incoming transaction into one word
    always_comb
    begin
        in_item.kind            = rec_in.kind;
        in_item.content_type    = rec_in.content_type;
        in_item.version_major   = rec_in.version_major;
        in_item.version_minor   = rec_in.version_minor;
        in_item.record_len      = rec_in.record_len;
        in_item.first_body_byte = rec_in.first_body_byte;
        in_item.explicit_nonce  = rec_in.explicit_nonce;
        in_item.tag_ok          = rec_in.tag_ok;
    end

    // Advance the pipe whenever the result register is free or being drained;
    // the input stage refills in the same cycle. A waiting result holds off the
    // input only once the input register is full as well.
    assign advance      = !out_valid_reg || res_out.ready;
    assign rec_in.ready = !s1_valid_reg || advance;
    assign in_take      = rec_in.valid && rec_in.ready;

    tls_rx_eval #(
        .MAX_PLAINTEXT  (MAX_PLAINTEXT),
        .MAX_CIPHERTEXT (MAX_CIPHERTEXT),
        .TAG_BYTES      (TAG_BYTES)
    ) u_eval (
        .item    (s1_item_reg),
        .st      (st_reg),
        .cfg     (cfg),
        .res     (eval_res),
        .st_next (st_eval)
    );

    // Control: stage valids and record state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            st_reg.first_record <= 1'b1;
            st_reg.read_seq     <= '0;
            st_reg.open_pending <= 1'b0;
            st_reg.pending_type <= '0;
            st_reg.pending_len  <= '0;
        end
        else
        begin
            if (rec_in.ready)
            begin
                s1_valid_reg <= rec_in.valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            // Commit the state left by the item as it moves into the result stage
            if (s1_valid_reg && advance)
            begin
                st_reg <= st_eval;
            end
            // Write read_active only while idle (not checked); restart the sequence
            else if (seq_clear)
            begin
                st_reg.read_seq <= '0;
            end
        end
    end

    // Payload: hold while stalled, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_valid_reg && advance)
        begin
            out_res_reg <= eval_res;
        end
    end

    assign res_out.valid       = out_valid_reg;
    assign res_out.status      = out_res_reg.status;
    assign res_out.alert_code  = out_res_reg.alert_code;
    assign res_out.plain_len   = out_res_reg.plain_len;
    assign res_out.body_offset = out_res_reg.body_offset;
    assign res_out.seq_used    = out_res_reg.seq_used;
    assign res_out.nonce_high  = out_res_reg.nonce_high;
    assign res_out.nonce_low   = out_res_reg.nonce_low;

endmodule

`default_nettype wire

[hdl/tls_rx_cfg.sv]
// Configuration register file of the record receive checker.
// Depends on tls_rx_pkg.
`default_nettype none

module tls_rx_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [tls_rx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tls_rx_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output tls_rx_pkg::cfg_t                      cfg,
    output logic                                  seq_clear
);
    import tls_rx_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_READ_ACTIVE: cfg_next.read_active = cfg_wdata[0];
                REG_AEAD_CHACHA: cfg_next.aead_chacha = cfg_wdata[0];
                REG_IV_HIGH:     cfg_next.iv_high     = cfg_wdata[31:0];
                REG_IV_LOW:      cfg_next.iv_low      = cfg_wdata;
                REG_SEQ_LIMIT:   cfg_next.seq_limit   = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.read_active <= 1'b0;
            cfg_reg.aead_chacha <= 1'b0;
            cfg_reg.iv_high     <= '0;
            cfg_reg.iv_low      <= '0;
            cfg_reg.seq_limit   <= '1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Any write of read_active restarts the read sequence
    assign seq_clear = cfg_we && (cfg_index == REG_READ_ACTIVE);
    assign cfg       = cfg_reg;

endmodule

`default_nettype wire

[hdl/tls_rx_eval.sv]
// Single-pass check of one registered item against the record state.
// Depends on tls_rx_pkg.
`default_nettype none

module tls_rx_eval #(
    parameter int MAX_PLAINTEXT  = tls_rx_pkg::MAX_PLAINTEXT,
    parameter int MAX_CIPHERTEXT = tls_rx_pkg::MAX_CIPHERTEXT,
    parameter int TAG_BYTES      = tls_rx_pkg::TAG_BYTES
) (
    input  tls_rx_pkg::item_t   item,
    input  tls_rx_pkg::state_t  st,
    input  tls_rx_pkg::cfg_t    cfg,
    output tls_rx_pkg::result_t res,
    output tls_rx_pkg::state_t  st_next
);
    import tls_rx_pkg::*;

    logic [3:0]  expl_bytes;
    logic [16:0] len_ext;
    logic [16:0] len_max;
    logic [16:0] len_min;
    logic [16:0] prot_plen;
    logic        seq_exhausted;
    logic        bad_type;
    logic        bad_version;
    logic        empty_ctrl_pend;
    logic        empty_ctrl_hdr;

    always_comb
    begin
        expl_bytes    = cfg.aead_chacha ? 4'd0 : GCM_EXPLICIT_BYTES;
        len_ext       = {1'b0, item.record_len};
        len_max       = cfg.read_active ? 17'(MAX_CIPHERTEXT) : 17'(MAX_PLAINTEXT);
        len_min       = 17'(expl_bytes) + 17'(TAG_BYTES);
        prot_plen     = len_ext - len_min;
        seq_exhausted = (st.read_seq == '1)
                     || (!cfg.aead_chacha && (st.read_seq >= cfg.seq_limit));
        bad_type      = (item.content_type < CT_CCS) || (item.content_type > CT_APPDATA)
                     || (item.version_major != VER_MAJOR_TLS);
        bad_version   = (item.version_minor != VER_MINOR_TLS12)
                     && !(st.first_record && !cfg.read_active
                          && (item.version_minor == VER_MINOR_TLS10));
        empty_ctrl_pend = ((st.pending_type == CT_HANDSHAKE)
                        || (st.pending_type == CT_ALERT)) && (st.pending_len == '0);
        empty_ctrl_hdr  = ((item.content_type == CT_HANDSHAKE)
                        || (item.content_type == CT_ALERT)) && (item.record_len == '0);
    end

    always_comb
    begin
        res            = '0;
        res.status     = ST_DELIVER;
        res.alert_code = ALERT_NONE;
        st_next        = st;
        st_next.open_pending = 1'b0;

        if (item.kind)
        begin
            // Open result from the cipher
            priority if (!st.open_pending)
            begin
                res.status     = ST_PROTO_ERR;
                res.alert_code = ALERT_UNEXPECTED;
            end
            else if (!item.tag_ok)
            begin
                res.status     = ST_MAC_ERR;
                res.alert_code = ALERT_BAD_MAC;
            end
            else
            begin
                st_next.read_seq = st.read_seq + 64'd1;
                if (empty_ctrl_pend)
                begin
                    res.status     = ST_PROTO_ERR;
                    res.alert_code = ALERT_UNEXPECTED;
                end
                else
                begin
                    st_next.first_record = 1'b0;
                    res.status = ((st.pending_len == '0) && (st.pending_type == CT_APPDATA))
                               ? ST_DROPPED : ST_DELIVER;
                    res.plain_len   = st.pending_len;
                    res.body_offset = expl_bytes;
                end
            end
        end
        else
        begin
            // Record header
            priority if (bad_type)
            begin
                res.status     = ST_PROTO_ERR;
                res.alert_code = ALERT_UNEXPECTED;
            end
            else if (bad_version)
            begin
                res.status     = ST_PROTO_ERR;
                res.alert_code = ALERT_BAD_VERSION;
            end
            else if (len_ext > len_max)
            begin
                res.status     = ST_PROTO_ERR;
                res.alert_code = ALERT_REC_OVERFLOW;
            end
            else if (item.content_type == CT_CCS)
            begin
                priority if (cfg.read_active)
                begin
                    res.status     = ST_PROTO_ERR;
                    res.alert_code = ALERT_UNEXPECTED;
                end
                else if ((item.record_len != CCS_LEN) || (item.first_body_byte != CCS_BODY))
                begin
                    res.status     = ST_PROTO_ERR;
                    res.alert_code = ALERT_DECODE;
                end
                else
                begin
                    st_next.first_record = 1'b0;
                    res.plain_len        = 15'd1;
                end
            end
            else if (cfg.read_active)
            begin
                priority if (len_ext < len_min)
                begin
                    res.status     = ST_PROTO_ERR;
                    res.alert_code = ALERT_DECODE;
                end
                else if (seq_exhausted)
                begin
                    res.status     = ST_PROTO_ERR;
                    res.alert_code = ALERT_UNEXPECTED;
                end
                else if (prot_plen > 17'(MAX_PLAINTEXT))
                begin
                    res.status     = ST_PROTO_ERR;
                    res.alert_code = ALERT_REC_OVERFLOW;
                end
                else
                begin
                    st_next.open_pending = 1'b1;
                    st_next.pending_type = item.content_type;
                    st_next.pending_len  = prot_plen[14:0];
                    res.status      = ST_OPEN;
                    res.plain_len   = prot_plen[14:0];
                    res.body_offset = expl_bytes;
                    res.seq_used    = st.read_seq;
                    res.nonce_high  = cfg.iv_high;
                    res.nonce_low   = cfg.aead_chacha ? (cfg.iv_low ^ st.read_seq)
                                                      : item.explicit_nonce;
                end
            end
            else if ((item.content_type == CT_APPDATA) || empty_ctrl_hdr)
            begin
                res.status     = ST_PROTO_ERR;
                res.alert_code = ALERT_UNEXPECTED;
            end
            else
            begin
                st_next.first_record = 1'b0;
                res.plain_len        = item.record_len[14:0];
            end
        end
    end

endmodule

`default_nettype wire

[tb/record_verdict_monitor.sv]
// Passive monitor for the TLS 1.2 record receive checker: mirrors the register writes,
// predicts one verdict per accepted record transaction and compares the results.
// Depends on tls_rx_pkg and the tls_rx_rec_if / tls_rx_res_if interfaces.

module record_verdict_monitor (
    input  logic                              clk,
    input  logic                              rst_n,
    tls_rx_rec_if                             rec,
    tls_rx_res_if                             res,
    input  logic                              cfg_we,
    input  logic [tls_rx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tls_rx_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                                mismatches,
    output int                                pending_verdicts,
    output int                                opens_seen,
    output int                                clean_seen,
    output int                                alerts_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import tls_rx_pkg::*;

    cfg_t    regs;
    state_t  rx;
    item_t   taken;
    result_t got;
    result_t want;
    result_t verdicts[$];

    function automatic result_t reject(input status_t s, input logic [7:0] alert);
        result_t r;
        r = '0;
        r.status = s;
        r.alert_code = alert;
        return r;
    endfunction

    // Judge one record transaction against the mirrored state; updates that state.
    function automatic result_t judge_record(input item_t it);
        result_t r;
        int      overhead;
        int      plen;
        r = '0;
        if (it.kind)
        begin
            if (!rx.open_pending)
                return reject(ST_PROTO_ERR, ALERT_UNEXPECTED);
            rx.open_pending = 1'b0;
            if (!it.tag_ok)
                return reject(ST_MAC_ERR, ALERT_BAD_MAC);
            rx.read_seq = rx.read_seq + 64'd1;
            if ((rx.pending_type == CT_HANDSHAKE || rx.pending_type == CT_ALERT)
                && rx.pending_len == '0)
                return reject(ST_PROTO_ERR, ALERT_UNEXPECTED);
            rx.first_record = 1'b0;
            r.status = (rx.pending_len == '0 && rx.pending_type == CT_APPDATA)
                       ? ST_DROPPED : ST_DELIVER;
            r.plain_len = rx.pending_len;
            r.body_offset = regs.aead_chacha ? 4'd0 : GCM_EXPLICIT_BYTES;
            return r;
        end

        // A fresh header abandons any open still outstanding
        rx.open_pending = 1'b0;

        if (it.content_type < CT_CCS || it.content_type > CT_APPDATA
            || it.version_major != VER_MAJOR_TLS)
            return reject(ST_PROTO_ERR, ALERT_UNEXPECTED);
        if (it.version_minor != VER_MINOR_TLS12
            && !(rx.first_record && !regs.read_active && it.version_minor == VER_MINOR_TLS10))
            return reject(ST_PROTO_ERR, ALERT_BAD_VERSION);
        if (int'(it.record_len) > (regs.read_active ? MAX_CIPHERTEXT : MAX_PLAINTEXT))
            return reject(ST_PROTO_ERR, ALERT_REC_OVERFLOW);

        if (it.content_type == CT_CCS)
        begin
            if (regs.read_active)
                return reject(ST_PROTO_ERR, ALERT_UNEXPECTED);
            if (it.record_len != CCS_LEN || it.first_body_byte != CCS_BODY)
                return reject(ST_PROTO_ERR, ALERT_DECODE);
            rx.first_record = 1'b0;
            r.status = ST_DELIVER;
            r.plain_len = 15'd1;
            return r;
        end

        if (regs.read_active)
        begin
            overhead = (regs.aead_chacha ? 0 : int'(GCM_EXPLICIT_BYTES)) + TAG_BYTES;
            if (int'(it.record_len) < overhead)
                return reject(ST_PROTO_ERR, ALERT_DECODE);
            if (rx.read_seq == '1 || (!regs.aead_chacha && rx.read_seq >= regs.seq_limit))
                return reject(ST_PROTO_ERR, ALERT_UNEXPECTED);
            plen = int'(it.record_len) - overhead;
            if (plen > MAX_PLAINTEXT)
                return reject(ST_PROTO_ERR, ALERT_REC_OVERFLOW);
            rx.open_pending = 1'b1;
            rx.pending_type = it.content_type;
            rx.pending_len = plen[14:0];
            r.status = ST_OPEN;
            r.plain_len = plen[14:0];
            r.body_offset = regs.aead_chacha ? 4'd0 : GCM_EXPLICIT_BYTES;
            r.seq_used = rx.read_seq;
            r.nonce_high = regs.iv_high;
            r.nonce_low = regs.aead_chacha ? (regs.iv_low ^ rx.read_seq) : it.explicit_nonce;
            return r;
        end

        if (it.content_type == CT_APPDATA)
            return reject(ST_PROTO_ERR, ALERT_UNEXPECTED);
        if ((it.content_type == CT_HANDSHAKE || it.content_type == CT_ALERT)
            && it.record_len == '0)
            return reject(ST_PROTO_ERR, ALERT_UNEXPECTED);
        rx.first_record = 1'b0;
        r.status = ST_DELIVER;
        r.plain_len = it.record_len[14:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs = '0;
            regs.seq_limit = '1;
            rx = '0;
            rx.first_record = 1'b1;
            verdicts.delete();
            mismatches = 0;
            opens_seen = 0;
            clean_seen = 0;
            alerts_seen = 0;
            pending_verdicts <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_READ_ACTIVE:
                    begin
                        regs.read_active = cfg_wdata[0];
                        rx.read_seq = '0;
                    end
                    REG_AEAD_CHACHA: regs.aead_chacha = cfg_wdata[0];
                    REG_IV_HIGH:     regs.iv_high = cfg_wdata[31:0];
                    REG_IV_LOW:      regs.iv_low = cfg_wdata;
                    REG_SEQ_LIMIT:   regs.seq_limit = cfg_wdata;
                    default: ;
                endcase
            end

            if (rec.valid && rec.ready)
            begin
                taken.kind = rec.kind;
                taken.content_type = rec.content_type;
                taken.version_major = rec.version_major;
                taken.version_minor = rec.version_minor;
                taken.record_len = rec.record_len;
                taken.first_body_byte = rec.first_body_byte;
                taken.explicit_nonce = rec.explicit_nonce;
                taken.tag_ok = rec.tag_ok;
                want = judge_record(taken);
                case (want.status)
                    ST_OPEN:               opens_seen++;
                    ST_DELIVER, ST_DROPPED: clean_seen++;
                    default:               alerts_seen++;
                endcase
                verdicts.push_back(want);
            end

            if (res.valid && res.ready)
            begin
                got.status = status_t'(res.status);
                got.alert_code = res.alert_code;
                got.plain_len = res.plain_len;
                got.body_offset = res.body_offset;
                got.seq_used = res.seq_used;
                got.nonce_high = res.nonce_high;
                got.nonce_low = res.nonce_low;
                if (verdicts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with none outstanding: status %0d alert %0d",
                                 $realtime, got.status, got.alert_code);
                end
                else
                begin
                    want = verdicts.pop_front();
                    if (got.status !== want.status || got.alert_code !== want.alert_code
                        || got.plain_len !== want.plain_len
                        || got.body_offset !== want.body_offset
                        || got.seq_used !== want.seq_used
                        || got.nonce_high !== want.nonce_high
                        || got.nonce_low !== want.nonce_low)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: verdict differs (expected / actual)", $realtime);
                            $display("  status %0d / %0d  alert %0d / %0d  len %0d / %0d",
                                     want.status, got.status, want.alert_code,
                                     got.alert_code, want.plain_len, got.plain_len);
                            $display("  offset %0d / %0d  seq %h / %h",
                                     want.body_offset, got.body_offset,
                                     want.seq_used, got.seq_used);
                            $display("  nonce %h_%h / %h_%h",
                                     want.nonce_high, want.nonce_low,
                                     got.nonce_high, got.nonce_low);
                        end
                    end
                end
            end

            pending_verdicts <= verdicts.size();
        end
    end

endmodule

[tb/testbench.sv]
// Top of the record receive checker bench: clock, reset, register programming and
// record stimulus with random idling; verdicts come from record_verdict_monitor.
// Depends on tls_rx_pkg, tls_rx_if and the tls12_record_receive_checker RTL.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tls_rx_pkg::*;

    localparam int SETTING_ROUNDS   = 8;
    localparam int ITEMS_PER_ROUND  = 210;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT      = 250000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    tls_rx_rec_if rec_ch ();
    tls_rx_res_if res_ch ();

    int mismatches;
    int pending_verdicts;
    int opens_seen;
    int clean_seen;
    int alerts_seen;
    int cycle_count;

    // Idling controls shared between the stimulus and the result sink
    bit source_calm;
    bit sink_calm;
    bit hold_sink;

    tls12_record_receive_checker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_in    (rec_ch),
        .res_out   (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    record_verdict_monitor CHK (
        .clk              (clk),
        .rst_n            (rst_n),
        .rec              (rec_ch),
        .res              (res_ch),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .mismatches       (mismatches),
        .pending_verdicts (pending_verdicts),
        .opens_seen       (opens_seen),
        .clean_seen       (clean_seen),
        .alerts_seen      (alerts_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: stop a hung run with a failing verdict.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Build a record header transaction; the nonce and the unused tag bit are random.
    function automatic item_t record_header(input logic [7:0] ct, input logic [7:0] minor,
                                            input int len, input logic [7:0] fbb);
        item_t it;
        it.kind = 1'b0;
        it.content_type = ct;
        it.version_major = VER_MAJOR_TLS;
        it.version_minor = minor;
        it.record_len = len[15:0];
        it.first_body_byte = fbb;
        it.explicit_nonce = {$urandom, $urandom};
        it.tag_ok = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Build an AEAD open result; header fields carry random junk the block must ignore.
    function automatic item_t open_verdict(input logic tag);
        logic [127:0] raw;
        item_t        it;
        raw = {$urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(item_t)-1:0];
        it.kind = 1'b1;
        it.tag_ok = tag;
        return it;
    endfunction

    // Plaintext size: mostly short, now and then empty or the largest allowed.
    function automatic int pick_plain_len();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return 0;
        if (roll == 1)
            return MAX_PLAINTEXT;
        return $urandom_range(1, 400);
    endfunction

    // Offer one record transaction after a random gap and hold it until accepted.
    // Valid stays high on return so back-to-back transactions need no extra edge.
    task automatic send_record(input item_t it);
        int gap;
        gap = source_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            rec_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rec_ch.valid <= 1'b1;
        rec_ch.kind <= it.kind;
        rec_ch.content_type <= it.content_type;
        rec_ch.version_major <= it.version_major;
        rec_ch.version_minor <= it.version_minor;
        rec_ch.record_len <= it.record_len;
        rec_ch.first_body_byte <= it.first_body_byte;
        rec_ch.explicit_nonce <= it.explicit_nonce;
        rec_ch.tag_ok <= it.tag_ok;
        @(posedge clk);
        while (!rec_ch.ready) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // Program every register; only ever called with the block idle.
    task automatic program_settings(input logic keys_on, input logic chacha,
                                    input logic [31:0] salt, input logic [63:0] iv_tail,
                                    input logic [63:0] limit);
        write_register(REG_AEAD_CHACHA, {63'd0, chacha});
        write_register(REG_IV_HIGH, {32'd0, salt});
        write_register(REG_IV_LOW, iv_tail);
        write_register(REG_SEQ_LIMIT, limit);
        write_register(REG_READ_ACTIVE, {63'd0, keys_on});
        cfg_we <= 1'b0;
    endtask

    // Drop valid, wait until every predicted verdict has been returned, and let the
    // two-stage pipeline idle before anything else is touched.
    task automatic settle();
        rec_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Result sink: random stall before each transaction, calm stretches, and one long
    // hold-off on request so the block backs up and stalls its input.
    initial
    begin
        int pause;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                sink_calm = !sink_calm;
            pause = sink_calm ? 0 : $urandom_range(0, 5);
            if (hold_sink)
            begin
                pause = SINK_HOLD_CYCLES;
                hold_sink = 1'b0;
            end
            if (pause > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid) @(posedge clk);
        end
    end

    initial
    begin
        item_t        it;
        logic [127:0] raw;
        logic [7:0]   ct;
        logic         keyed;
        logic         chacha;
        logic [31:0]  salt;
        logic [63:0]  iv_tail;
        logic [63:0]  limit;
        int           round;
        int           sent;
        int           pick;
        int           len;
        int           overhead;

        // Known values on every input from time zero
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_READ_ACTIVE;
        cfg_wdata = '0;
        rec_ch.valid = 1'b0;
        rec_ch.kind = 1'b0;
        rec_ch.content_type = '0;
        rec_ch.version_major = '0;
        rec_ch.version_minor = '0;
        rec_ch.record_len = '0;
        rec_ch.first_body_byte = '0;
        rec_ch.explicit_nonce = '0;
        rec_ch.tag_ok = 1'b0;
        source_calm = 1'b0;
        sink_calm = 1'b0;
        hold_sink = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, keys off and no record accepted yet. Every record here is
        // rejected, so the first-record allowance for version 3.1 stays open.
        send_record(open_verdict(1'b1));                          // open with nothing outstanding
        send_record(record_header(CT_CCS - 8'd1, VER_MINOR_TLS12, 10, 8'd0));
        send_record(record_header(8'hFF, VER_MINOR_TLS12, 10, 8'd0));
        it = record_header(CT_HANDSHAKE, VER_MINOR_TLS12, 10, 8'd0);
        it.version_major = 8'hFF;
        send_record(it);
        send_record(record_header(CT_HANDSHAKE, 8'h00, 10, 8'd0));
        send_record(record_header(CT_HANDSHAKE, VER_MINOR_TLS12, MAX_PLAINTEXT + 1, 8'd0));
        send_record(record_header(CT_CCS, VER_MINOR_TLS12, 2, CCS_BODY));
        send_record(record_header(CT_CCS, VER_MINOR_TLS12, CCS_LEN, 8'h00));
        send_record(record_header(CT_HANDSHAKE, VER_MINOR_TLS12, 0, 8'd0));
        send_record(record_header(CT_ALERT, VER_MINOR_TLS12, 0, 8'd0));
        send_record(record_header(CT_APPDATA, VER_MINOR_TLS12, 4, 8'd0));

        // Keys on while still on the first record: 3.1 is refused, and so is CCS.
        settle();
        program_settings(1'b1, 1'b0, $urandom, {$urandom, $urandom}, '1);
        send_record(record_header(CT_HANDSHAKE, VER_MINOR_TLS10, 40, 8'd0));
        send_record(record_header(CT_CCS, VER_MINOR_TLS12, CCS_LEN, CCS_BODY));
        send_record(record_header(CT_APPDATA, VER_MINOR_TLS12, TAG_BYTES + 7, 8'd0));
        send_record(record_header(CT_APPDATA, VER_MINOR_TLS12, MAX_CIPHERTEXT, 8'd0));

        // Keys off again: accept 3.1 once at the largest plaintext, then refuse it.
        settle();
        program_settings(1'b0, 1'b0, '0, '0, '1);
        send_record(record_header(CT_HANDSHAKE, VER_MINOR_TLS10, MAX_PLAINTEXT, 8'd0));
        send_record(record_header(CT_HANDSHAKE, VER_MINOR_TLS10, 1, 8'd0));
        send_record(record_header(CT_CCS, VER_MINOR_TLS12, CCS_LEN, CCS_BODY));
        send_record(record_header(CT_ALERT, VER_MINOR_TLS12, 2, 8'd0));

        // GCM keys: empty application data dropped, empty handshake refused after a
        // good tag, bad tag on the largest record, and a header abandoning an open.
        settle();
        program_settings(1'b1, 1'b0, $urandom, {$urandom, $urandom}, '1);
        it = record_header(CT_APPDATA, VER_MINOR_TLS12, TAG_BYTES + 8, 8'd0);
        it.explicit_nonce = '1;
        send_record(it);
        send_record(open_verdict(1'b1));
        send_record(record_header(CT_HANDSHAKE, VER_MINOR_TLS12, TAG_BYTES + 8, 8'd0));
        send_record(open_verdict(1'b1));
        send_record(record_header(CT_APPDATA, VER_MINOR_TLS12, MAX_PLAINTEXT + 24, 8'd0));
        send_record(open_verdict(1'b0));
        send_record(record_header(CT_ALERT, VER_MINOR_TLS12, 26, 8'd0));
        send_record(record_header(CT_APPDATA, VER_MINOR_TLS12, 30, 8'd0));
        send_record(open_verdict(1'b1));
        send_record(open_verdict(1'b1));

        // Random part: one register setting per round. The first two rounds take the
        // extremes (all zeros with ChaCha, all ones with GCM); later ones draw freely,
        // with short sequence limits so GCM exhaustion is reached.
        for (round = 0; round < SETTING_ROUNDS; round++)
        begin
            settle();
            keyed = (round % 4 != 3);
            chacha = (round % 2 == 0);
            if (round == 0)
            begin
                salt = '0;
                iv_tail = '0;
                limit = '0;
            end
            else if (round == 1)
            begin
                salt = '1;
                iv_tail = '1;
                limit = '1;
            end
            else
            begin
                salt = $urandom;
                iv_tail = {$urandom, $urandom};
                case ($urandom_range(0, 3))
                    0:       limit = '1;
                    1:       limit = 64'($urandom_range(1, 24));
                    2:       limit = {$urandom, $urandom};
                    default: limit = '0;
                endcase
            end
            program_settings(keyed, chacha, salt, iv_tail, limit);

            // Stall the sink for a long stretch while records keep coming
            if (round == 2)
                hold_sink = 1'b1;

            overhead = (chacha ? 0 : int'(GCM_EXPLICIT_BYTES)) + TAG_BYTES;
            sent = 0;
            while (sent < ITEMS_PER_ROUND)
            begin
                if ($urandom_range(0, 39) == 0)
                    source_calm = !source_calm;
                pick = $urandom_range(0, 99);
                if (pick < 15)
                begin
                    // Noise: every field random, half of it with a plausible type/version
                    raw = {$urandom, $urandom, $urandom, $urandom};
                    it = raw[$bits(item_t)-1:0];
                    if ($urandom_range(0, 1) == 1)
                    begin
                        it.version_major = VER_MAJOR_TLS;
                        it.content_type = 8'($urandom_range(CT_CCS, CT_APPDATA));
                    end
                    send_record(it);
                    sent++;
                end
                else if (keyed)
                begin
                    // Header then open result; a few broken lengths, stray 3.1,
                    // missing opens and doubled opens
                    len = (pick < 20) ? $urandom_range(0, MAX_CIPHERTEXT + 64)
                                      : overhead + pick_plain_len();
                    send_record(record_header(8'($urandom_range(CT_ALERT, CT_APPDATA)),
                                              (pick < 23) ? VER_MINOR_TLS10 : VER_MINOR_TLS12,
                                              len, 8'($urandom)));
                    sent++;
                    if (pick >= 25)
                    begin
                        send_record(open_verdict($urandom_range(0, 9) != 0));
                        sent++;
                    end
                    if (pick >= 97)
                    begin
                        send_record(open_verdict(1'b1));
                        sent++;
                    end
                end
                else
                begin
                    // Plaintext records: CCS mostly well formed, others mostly 3.3
                    ct = 8'($urandom_range(CT_CCS, CT_HANDSHAKE));
                    if (ct == CT_CCS)
                        send_record(record_header(ct, VER_MINOR_TLS12,
                                                  (pick < 25) ? $urandom_range(0, 3)
                                                              : int'(CCS_LEN),
                                                  (pick < 20) ? 8'($urandom) : CCS_BODY));
                    else
                        send_record(record_header(ct,
                                                  (pick < 20) ? 8'($urandom) : VER_MINOR_TLS12,
                                                  pick_plain_len(), 8'($urandom)));
                    sent++;
                end
            end
        end

        // Drain and judge
        settle();
        repeat (8) @(posedge clk);
        $display("Covered %0d verdicts over %0d register settings:",
                 opens_seen + clean_seen + alerts_seen, SETTING_ROUNDS + 3);
        $display("  %0d protected opens, %0d deliveries or drops, %0d alerts",
                 opens_seen, clean_seen, alerts_seen);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
